// ===== hdl/gdd_pkg.sv =====
// Shared types, constants and calendar tables for the date difference core.
package gdd_pkg;

	// Width of a linear day number after the 400-year shift.
	localparam int NumW = 23;

	localparam int YEAR_LIMIT = 9999;

	localparam logic [21:0] COUNT_MAX = 22'd4194303;

	// Reciprocal of 100 scaled by 2^19; exact for the year range in use.
	localparam logic [12:0] RECIP100 = 13'd5243;
	localparam int RecipShift = 19;

	localparam logic [1:0] ORD_LESS    = 2'd0;
	localparam logic [1:0] ORD_EQUAL   = 2'd1;
	localparam logic [1:0] ORD_GREATER = 2'd2;

	// Load enables for the three conversion stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} gdd_adv_t;

	// Length of a month in a common year.
	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd2:                       len = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
			default:                    len = 5'd31;
		endcase
		return len;
	endfunction

	// Days before a month in a year that starts in March.
	function automatic logic [8:0] month_offset(input logic [3:0] mm);
		logic [8:0] off;
		case (mm)
			4'd0:    off = 9'd0;
			4'd1:    off = 9'd31;
			4'd2:    off = 9'd61;
			4'd3:    off = 9'd92;
			4'd4:    off = 9'd122;
			4'd5:    off = 9'd153;
			4'd6:    off = 9'd184;
			4'd7:    off = 9'd214;
			4'd8:    off = 9'd245;
			4'd9:    off = 9'd275;
			4'd10:   off = 9'd306;
			4'd11:   off = 9'd337;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

endpackage

// ===== hdl/gdd_date_conv.sv =====
// Three-stage conversion of one date into a linear day number with a validity flag.
module gdd_date_conv import gdd_pkg::*; (
	input  logic            clk,
	input  gdd_adv_t        adv,
	input  logic [4:0]      day,
	input  logic [3:0]      month,
	input  logic [13:0]     year,
	output logic [NumW-1:0] num_s3,
	output logic            ok_s3
);

	// Stage 1: shifted year, March-based month, divisions by 100.
	logic [14:0] yy;
	logic [3:0]  mm;
	logic [26:0] prod_y;
	logic [27:0] prod_yy;

	logic [13:0] y_s1;
	logic [14:0] yy_s1;
	logic [3:0]  mm_s1;
	logic [4:0]  d_s1;
	logic [7:0]  qy_s1;
	logic [7:0]  qyy_s1;
	logic [4:0]  len_s1;
	logic        feb_s1;
	logic        basic_s1;

	always_comb begin
		if (month <= 4'd2) begin
			yy = 15'(year) + 15'd399;
			mm = month + 4'd9;
		end else begin
			yy = 15'(year) + 15'd400;
			mm = month - 4'd3;
		end
		prod_y  = 27'(year) * 27'(RECIP100);
		prod_yy = 28'(yy) * 28'(RECIP100);
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			y_s1     <= year;
			yy_s1    <= yy;
			mm_s1    <= mm;
			d_s1     <= day;
			qy_s1    <= prod_y[RecipShift+7:RecipShift];
			qyy_s1   <= prod_yy[RecipShift+7:RecipShift];
			len_s1   <= month_len(month);
			feb_s1   <= (month == 4'd2);
			basic_s1 <= (month >= 4'd1) && (month <= 4'd12) &&
				(year <= 14'(YEAR_LIMIT)) && (day != 5'd0);
		end
	end

	// Stage 2: leap year and day check, then the two partial sums.
	logic [13:0] rem_y;
	logic        leap;
	logic [4:0]  len;

	logic [NumW-1:0] part1_s2;
	logic [9:0]      part2_s2;
	logic [7:0]      qyy_s2;
	logic            ok_s2;

	always_comb begin
		rem_y = y_s1 - 14'(qy_s1) * 14'd100;
		// Divisible by 400 exactly when divisible by 100 with a quotient divisible by 4.
		leap = ((y_s1[1:0] == 2'd0) && (rem_y != 14'd0)) ||
			((rem_y == 14'd0) && (qy_s1[1:0] == 2'd0));
		len = (feb_s1 && leap) ? 5'd29 : len_s1;
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			part1_s2 <= NumW'(yy_s1) * NumW'(365) + NumW'(yy_s1 >> 2);
			part2_s2 <= 10'(month_offset(mm_s1)) + 10'(d_s1) + 10'(qyy_s1 >> 2) - 10'd1;
			qyy_s2   <= qyy_s1;
			ok_s2    <= basic_s1 && (d_s1 <= len);
		end
	end

	// Stage 3: final day number.
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			num_s3 <= part1_s2 - NumW'(qyy_s2) + NumW'(part2_s2);
			ok_s3  <= ok_s2;
		end
	end

endmodule

// ===== hdl/gdd_compare.sv =====
// Output stage: orders two day numbers and forms the saturated absolute difference.
module gdd_compare import gdd_pkg::*; (
	input  logic            clk,
	input  logic            load,
	input  logic [NumW-1:0] num_a,
	input  logic            ok_a,
	input  logic [NumW-1:0] num_b,
	input  logic            ok_b,
	output logic [1:0]      order_s4,
	output logic [21:0]     count_s4,
	output logic            invalid_s4
);

	logic [NumW-1:0] diff;
	logic [1:0]      order;

	always_comb begin
		if (num_a < num_b) begin
			order = ORD_LESS;
			diff  = num_b - num_a;
		end else if (num_a == num_b) begin
			order = ORD_EQUAL;
			diff  = '0;
		end else begin
			order = ORD_GREATER;
			diff  = num_a - num_b;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (!(ok_a && ok_b)) begin
				order_s4   <= ORD_LESS;
				count_s4   <= '0;
				invalid_s4 <= 1'b1;
			end else begin
				order_s4   <= order;
				count_s4   <= (diff > NumW'(COUNT_MAX)) ? COUNT_MAX : diff[21:0];
				invalid_s4 <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/gregorian_date_difference_core.sv =====
// Top level of the Gregorian date difference core: four-stage pipeline with stream ports.
//
// Channel  | Dir | Beat contents
// ---------+-----+-------------------------------------------------------------
// s_axis   | in  | two dates: day, month, year of the first, then of the second
// m_axis   | out | order and absolute day count in tdata, invalid flag in tuser
//
// A result passes through the stage registers s1, s2, s3 and s4 on its way to m_axis,
// and a new pair of dates can be taken in every cycle unless m_tready stalls the
// pipeline; the depth is set by the day-number conversion (three stages) followed
// by the compare and subtract stage.
// Each stage holds its own valid bit and loads whenever it is empty or its
// successor moves on, so bubbles are squeezed out and a stall on m_tready backs
// up stage by stage without losing or repeating a beat.
// Reset clears only the valid bits; the data registers hold no reset value.
module gregorian_date_difference_core import gdd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// first_day[4:0], first_month[8:5], first_year[22:9],
	// second_day[27:23], second_month[31:28], second_year[45:32], zero fill [47:46]
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// order[1:0], day_count[23:2]
	output logic [23:0] m_tdata,
	// invalid[0]
	output logic        m_tuser
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	gdd_adv_t adv;

	// A stage may load when it is empty or when its contents move on this cycle.
	assign rdy4 = !v_s4 || m_tready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign adv.s1 = rdy1;
	assign adv.s2 = rdy2;
	assign adv.s3 = rdy3;

	assign s_tready = rdy1;
	assign m_tvalid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Both dates are converted side by side by identical pipelines.
	logic [NumW-1:0] num_a_s3, num_b_s3;
	logic            ok_a_s3, ok_b_s3;

	gdd_date_conv u_conv_a (
		.clk    (clk),
		.adv    (adv),
		.day    (s_tdata[4:0]),
		.month  (s_tdata[8:5]),
		.year   (s_tdata[22:9]),
		.num_s3 (num_a_s3),
		.ok_s3  (ok_a_s3)
	);

	gdd_date_conv u_conv_b (
		.clk    (clk),
		.adv    (adv),
		.day    (s_tdata[27:23]),
		.month  (s_tdata[31:28]),
		.year   (s_tdata[45:32]),
		.num_s3 (num_b_s3),
		.ok_s3  (ok_b_s3)
	);

	logic [1:0]  order_s4;
	logic [21:0] count_s4;
	logic        invalid_s4;

	gdd_compare u_compare (
		.clk        (clk),
		.load       (rdy4),
		.num_a      (num_a_s3),
		.ok_a       (ok_a_s3),
		.num_b      (num_b_s3),
		.ok_b       (ok_b_s3),
		.order_s4   (order_s4),
		.count_s4   (count_s4),
		.invalid_s4 (invalid_s4)
	);

	assign m_tdata = {count_s4, order_s4};
	assign m_tuser = invalid_s4;

	// An accepted beat always occupies the first stage on the next cycle.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted beat did not enter the first stage");

	// An invalid result carries zero order and zero count.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (order_s4 == ORD_LESS) && (count_s4 == 22'd0))
		else $error("invalid result with non-zero fields");

	// Equal dates give a zero count, and unequal valid dates a non-zero one.
	a_equal_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> ((order_s4 == ORD_EQUAL) == (count_s4 == 22'd0)))
		else $error("order and day count disagree");

	// A stalled output stage keeps the beat behind it from being overwritten.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !m_tready && v_s3 |=> v_s3 && $stable(num_a_s3) && $stable(num_b_s3))
		else $error("stage three changed while the output was stalled");

endmodule
